// ===== hdl/tss_pkg.sv =====
package tss_pkg;

	localparam int RSSI_ENTRIES_DEF  = 16;
	localparam int TRAILER_BYTES_DEF = 2;
	localparam int Q_DEPTH           = 2;

	localparam logic [15:0] SLOT_TICKS  = 16'd762;
	localparam logic [15:0] GUARD_TICKS = 16'd125;
	localparam logic [15:0] QUIET_EDGE  = SLOT_TICKS - GUARD_TICKS;
	localparam logic [15:0] LINK_PERIOD = 16'd31250;
	localparam logic [7:0]  ROM_LAST    = 8'd60;
	localparam logic [7:0]  SAT_MAX     = 8'hFF;

	localparam logic [8:0] SYNC_ROM [61] = '{
		9'd489, 9'd482, 9'd474, 9'd466, 9'd457, 9'd449, 9'd441, 9'd433, 9'd425, 9'd416,
		9'd408, 9'd400, 9'd392, 9'd383, 9'd375, 9'd367, 9'd359, 9'd350, 9'd342, 9'd334,
		9'd326, 9'd317, 9'd309, 9'd301, 9'd293, 9'd284, 9'd276, 9'd268, 9'd260, 9'd252,
		9'd243, 9'd235, 9'd227, 9'd219, 9'd210, 9'd202, 9'd194, 9'd186, 9'd177, 9'd169,
		9'd161, 9'd153, 9'd144, 9'd136, 9'd128, 9'd120, 9'd111, 9'd103, 9'd95,  9'd87,
		9'd78,  9'd77,  9'd69,  9'd60,  9'd52,  9'd44,  9'd36,  9'd27,  9'd19,  9'd11,
		9'd3
	};

	typedef enum logic [0:0] {
		CFG_OWN_NODE   = 1'b0,
		CFG_NODE_TOTAL = 1'b1
	} cfg_reg_e;

	typedef struct packed {
		logic       we;
		cfg_reg_e   index;
		logic [7:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic        func;
		logic [15:0] time_now;
		logic [7:0]  pkt_len;
		logic [7:0]  sender_id;
		logic [7:0]  packet_rssi;
		logic        config_mode;
		logic        report_more;
	} in_item_t;

	typedef struct packed {
		logic        send_data;
		logic        send_sync;
		logic [7:0]  trailer_hops;
		logic        forward_user;
		logic [7:0]  forward_len;
		logic        report_rssi;
		logic [7:0]  report_index;
		logic [7:0]  report_value;
		logic        synced;
		logic [7:0]  slot_now;
		logic        silent;
		logic        link_led;
	} out_item_t;

	typedef struct packed {
		logic        pkt;
		logic        is_sync;
		logic        fwd_ok;
		logic        rssi_store;
		logic [15:0] time_now;
		logic [8:0]  sync_ticks;
		logic [7:0]  payload;
		logic [7:0]  sender_id;
		logic [7:0]  packet_rssi;
		logic        config_mode;
		logic        report_more;
	} cls_item_t;

endpackage

// ===== hdl/tss_front.sv =====
module tss_front
	import tss_pkg::*;
#(
	parameter int RSSI_ENTRIES  = RSSI_ENTRIES_DEF,
	parameter int TRAILER_BYTES = TRAILER_BYTES_DEF
) (
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	input  logic      q_full,
	output logic      push,
	output cls_item_t cls
);

	localparam logic [8:0] ENT9 = 9'(RSSI_ENTRIES);

	logic [7:0] payload;
	logic [7:0] rom_idx;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign payload  = in_data.pkt_len - 8'(TRAILER_BYTES);
	assign rom_idx  = (in_data.pkt_len > ROM_LAST) ? ROM_LAST : in_data.pkt_len;

	always_comb begin
		cls.pkt         = in_data.func;
		cls.is_sync     = in_data.sender_id[7];
		cls.fwd_ok      = (payload != 8'd0) && !in_data.config_mode;
		cls.rssi_store  = in_data.func && ({1'b0, in_data.sender_id} < ENT9);
		cls.time_now    = in_data.time_now;
		cls.sync_ticks  = SYNC_ROM[rom_idx[5:0]];
		cls.payload     = payload;
		cls.sender_id   = in_data.sender_id;
		cls.packet_rssi = in_data.packet_rssi;
		cls.config_mode = in_data.config_mode;
		cls.report_more = in_data.report_more;
	end

endmodule

// ===== hdl/tss_queue.sv =====
module tss_queue
	import tss_pkg::*;
#(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t wr_data,
	output logic      full,
	input  logic      pop,
	output logic      rd_valid,
	output cls_item_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	cls_item_t         buf_q [DEPTH];
	logic [AW-1:0]     wp_q, rp_q;
	logic [CW-1:0]     cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/tss_back.sv =====
module tss_back
	import tss_pkg::*;
#(
	parameter int RSSI_ENTRIES = RSSI_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_wr_t   cfg,
	input  logic      q_valid,
	input  cls_item_t c,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int IW = (RSSI_ENTRIES > 1) ? $clog2(RSSI_ENTRIES) : 1;
	localparam logic [8:0] ENT9 = 9'(RSSI_ENTRIES);

	logic [7:0]  own_q, nt_q, slot_q, tally_q, hop_q, rcount_q;
	logic [15:0] ticks_q, last_q, lchk_q;
	logic        insync_q, sent_q, seen_q, blink_q, reporting_q, led_q;

	logic [7:0]  mem_q [RSSI_ENTRIES];
	logic        vld_q [RSSI_ENTRIES];
	logic [7:0]  rd_data_q;
	logic        rd_ok_q;

	logic        out_valid_q;
	out_item_t   out_q;

	logic [7:0]  slot_d, tally_d, hop_d, rcount_d, rc_inc;
	logic [15:0] ticks_d, last_d, lchk_d, lc_dt, dt, ov;
	logic        insync_d, sent_d, silence_d, seen_d, blink_d, reporting_d, led_d;
	logic        mem_we, raddr_in, rd_hit;
	logic [IW-1:0] waddr, raddr;
	out_item_t   o;

	assign pop       = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		lchk_d      = lchk_q;
		seen_d      = seen_q;
		led_d       = led_q;
		blink_d     = blink_q;
		insync_d    = insync_q;
		tally_d     = tally_q;
		slot_d      = slot_q;
		sent_d      = sent_q;
		hop_d       = hop_q;
		rcount_d    = rcount_q;
		reporting_d = reporting_q;
		rc_inc      = (rcount_q != SAT_MAX) ? rcount_q + 8'd1 : rcount_q;
		o           = '0;

		lc_dt = c.time_now - lchk_q;
		if (lc_dt > LINK_PERIOD) begin
			lchk_d = c.time_now;
			if (seen_q || own_q == 8'd0) begin
				seen_d = 1'b0;
				led_d  = 1'b1;
			end else begin
				tally_d  = 8'd0;
				led_d    = blink_q;
				blink_d  = !blink_q;
				insync_d = 1'b0;
			end
		end

		dt     = c.time_now - last_q;
		last_d = c.time_now;
		ov     = dt - ticks_q;
		if (dt >= ticks_q) begin
			ticks_d = SLOT_TICKS - ov;
			if (insync_d) begin
				sent_d = 1'b0;
				slot_d = (slot_q == nt_q) ? 8'd0 : slot_q + 8'd1;
			end else begin
				slot_d = nt_q;
			end
		end else begin
			ticks_d = ticks_q - dt;
		end
		silence_d = (ticks_d >= QUIET_EDGE);

		if (c.pkt) begin
			if (c.is_sync) begin
				if (tally_d != SAT_MAX) begin
					tally_d = tally_d + 8'd1;
				end
				last_d   = c.time_now;
				ticks_d  = {7'd0, c.sync_ticks};
				seen_d   = 1'b1;
				hop_d    = 8'd1;
				slot_d   = nt_q;
				insync_d = 1'b1;
			end else if (c.fwd_ok) begin
				o.forward_user = 1'b1;
				o.forward_len  = c.payload;
			end
		end else if (slot_d == own_q && insync_d && !sent_d && !silence_d) begin
			o.send_data    = 1'b1;
			o.trailer_hops = (own_q == 8'd0) ? 8'd0 : hop_q;
			sent_d         = 1'b1;
			rcount_d       = 8'd0;
			reporting_d    = 1'b1;
		end else if (slot_d == nt_q) begin
			if (own_q == 8'd0 && !silence_d && !sent_d) begin
				sent_d      = 1'b1;
				o.send_sync = 1'b1;
			end
			if (!c.config_mode && reporting_q) begin
				o.report_rssi  = 1'b1;
				o.report_index = rcount_q;
				o.report_value = ({1'b0, rcount_q} < ENT9 && rd_ok_q) ? rd_data_q : 8'd0;
				rcount_d       = rc_inc;
				reporting_d    = c.report_more;
				if ({1'b0, rc_inc} >= ENT9 || rc_inc >= nt_q) begin
					reporting_d = 1'b0;
				end
			end
		end

		o.synced   = insync_d;
		o.slot_now = slot_d;
		o.silent   = silence_d;
		o.link_led = led_d;
	end

	assign mem_we   = pop && c.rssi_store;
	assign waddr    = c.sender_id[IW-1:0];
	assign raddr    = pop ? rcount_d[IW-1:0] : rcount_q[IW-1:0];
	assign raddr_in = pop ? ({1'b0, rcount_d} < ENT9) : ({1'b0, rcount_q} < ENT9);
	assign rd_hit   = mem_we && (waddr == raddr);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= c.packet_rssi;
		end
		if (rd_hit) begin
			rd_data_q <= c.packet_rssi;
		end else if (raddr_in) begin
			rd_data_q <= mem_q[raddr];
		end
		if (pop) begin
			out_q <= o;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RSSI_ENTRIES; i++) begin
				vld_q[i] <= 1'b0;
			end
			rd_ok_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[waddr] <= 1'b1;
			end
			rd_ok_q <= rd_hit || (raddr_in && vld_q[raddr]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q       <= 8'd0;
			nt_q        <= 8'd1;
			slot_q      <= 8'd1;
			ticks_q     <= SLOT_TICKS;
			last_q      <= 16'd0;
			lchk_q      <= 16'd0;
			insync_q    <= 1'b1;
			sent_q      <= 1'b0;
			seen_q      <= 1'b0;
			tally_q     <= 8'd0;
			hop_q       <= 8'd0;
			blink_q     <= 1'b0;
			reporting_q <= 1'b1;
			rcount_q    <= 8'd0;
			led_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.we) begin
				unique case (cfg.index)
					CFG_OWN_NODE: begin
						own_q    <= cfg.data;
						insync_q <= (cfg.data == 8'd0);
					end
					CFG_NODE_TOTAL: begin
						nt_q   <= cfg.data;
						slot_q <= cfg.data;
					end
				endcase
			end else if (pop) begin
				slot_q      <= slot_d;
				ticks_q     <= ticks_d;
				last_q      <= last_d;
				lchk_q      <= lchk_d;
				insync_q    <= insync_d;
				sent_q      <= sent_d;
				seen_q      <= seen_d;
				tally_q     <= tally_d;
				hop_q       <= hop_d;
				blink_q     <= blink_d;
				reporting_q <= reporting_d;
				rcount_q    <= rcount_d;
				led_q       <= led_d;
			end
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= nt_q)
		else $error("slot index beyond sync slot");

	a_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped item produced no result");

	a_one_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.send_data && out_q.send_sync))
		else $error("data and sync transmit requested together");

	a_tx_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.send_data || out_q.send_sync) |-> !out_q.silent)
		else $error("transmit requested during guard");

	a_rep_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.report_rssi |->
			out_q.report_index == 8'd0 && out_q.report_value == 8'd0)
		else $error("report fields set without report");

endmodule

// ===== hdl/tdm_slot_scheduler_top.sv =====
// TDM slot scheduler.
// Input channel (in_valid/in_stall/in_data) carries one event per transfer: a timer
// poll or a received packet, each stamped with the free-running tick. Every event
// yields exactly one result on the output channel (out_valid/out_stall/out_data):
// transmit requests, forward and RSSI report requests, sync state, slot and LED.
// Configuration: cfg_we with cfg_index (own_node, node_total) and cfg_data, to be
// written by the user only while no event is in flight; the block does not enforce
// it. Writing node_total moves to the sync slot. Front end classifies the event
// (sync ROM lookup, payload length) into a two-entry queue; the back end updates the
// scheduler state and registers the result. Throughput: one event per cycle while
// the receiver does not stall. Results are registered after the queue, so out_valid
// follows the input transfer through the queue and the output register. RSSI storage
// reads through a registered port, refreshed with write bypass for in-range indices.
// Reset: base node, two slots, in the sync slot with a full slot of ticks, RSSI
// entries read as zero. A stalled receiver holds the result; the queue then fills
// and in_stall rises once both queue entries are taken.
module tdm_slot_scheduler_top
	import tss_pkg::*;
#(
	parameter int RSSI_ENTRIES  = RSSI_ENTRIES_DEF,
	parameter int TRAILER_BYTES = TRAILER_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  cfg_reg_e  cfg_index,
	input  logic [7:0] cfg_data
);

	logic      q_full, push, pop, q_valid;
	cls_item_t cls, q_item;
	cfg_wr_t   cfg;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	tss_front #(
		.RSSI_ENTRIES (RSSI_ENTRIES),
		.TRAILER_BYTES(TRAILER_BYTES)
	) u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data (in_data),
		.q_full  (q_full),
		.push    (push),
		.cls     (cls)
	);

	tss_queue #(
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cls),
		.full    (q_full),
		.pop     (pop),
		.rd_valid(q_valid),
		.rd_data (q_item)
	);

	tss_back #(
		.RSSI_ENTRIES(RSSI_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.c        (q_item),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ===== dv/tb.sv =====
module tb;
	import tss_pkg::*;

	localparam int N_RSSI  = RSSI_ENTRIES_DEF;
	localparam int TRAILER = TRAILER_BYTES_DEF;

	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t want;
	} row_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_we = 1'b0;
	cfg_reg_e  cfg_index = CFG_OWN_NODE;
	logic [7:0] cfg_data = 8'd0;

	// scheduler state as predicted
	logic [7:0]  p_own, p_total, p_slot, p_hops, p_rep_cnt;
	logic [15:0] p_ticks, p_last, p_link_t;
	logic        p_insync, p_sent, p_quiet, p_sync_seen, p_blink, p_reporting, p_led;
	logic [7:0]  p_rssi [N_RSSI];

	out_item_t   pending_res [$];
	row_t        plan [$];
	logic [15:0] tick = 16'd4100;
	int          errs = 0;
	int          src_idle = 10;
	int          sink_idle = 83;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	tdm_slot_scheduler_top #(
		.RSSI_ENTRIES(N_RSSI),
		.TRAILER_BYTES(TRAILER)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#3000000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic void reset_sched();
		p_own = 8'd0;
		p_total = 8'd1;
		p_slot = 8'd1;
		p_ticks = SLOT_TICKS;
		p_last = 16'd0;
		p_link_t = 16'd0;
		p_insync = 1'b1;
		p_sent = 1'b0;
		p_quiet = 1'b1;
		p_sync_seen = 1'b0;
		p_hops = 8'd0;
		p_blink = 1'b0;
		p_reporting = 1'b1;
		p_rep_cnt = 8'd0;
		p_led = 1'b0;
		for (int i = 0; i < N_RSSI; i++)
			p_rssi[i] = 8'd0;
	endfunction

	function automatic out_item_t sched_step(in_item_t it);
		out_item_t r;
		logic [15:0] dt;
		logic [7:0] payload;
		logic [7:0] ri;
		r = '0;
		dt = it.time_now - p_link_t;
		if (dt > LINK_PERIOD) begin
			p_link_t = it.time_now;
			if (p_sync_seen || p_own == 8'd0) begin
				p_sync_seen = 1'b0;
				p_led = 1'b1;
			end else begin
				p_led = p_blink;
				p_blink = !p_blink;
				p_insync = 1'b0;
			end
		end
		dt = it.time_now - p_last;
		p_last = it.time_now;
		if (dt >= p_ticks) begin
			dt = dt - p_ticks;
			p_ticks = SLOT_TICKS - dt;
			if (p_insync) begin
				p_sent = 1'b0;
				p_slot = (p_slot == p_total) ? 8'd0 : p_slot + 8'd1;
			end else begin
				p_slot = p_total;
			end
		end else begin
			p_ticks = p_ticks - dt;
		end
		p_quiet = !(int'(p_ticks) + int'(GUARD_TICKS) < int'(SLOT_TICKS));
		if (it.func) begin
			payload = it.pkt_len - 8'(TRAILER);
			if (it.sender_id[7]) begin
				ri = (it.pkt_len <= ROM_LAST) ? it.pkt_len : ROM_LAST;
				p_last = it.time_now;
				p_ticks = {7'd0, SYNC_ROM[ri]};
				p_sync_seen = 1'b1;
				p_hops = 8'd1;
				p_slot = p_total;
				p_insync = 1'b1;
			end else if (payload != 8'd0 && !it.config_mode) begin
				r.forward_user = 1'b1;
				r.forward_len = payload;
			end
			if (int'(it.sender_id) < N_RSSI)
				p_rssi[it.sender_id] = it.packet_rssi;
		end else if (p_slot == p_own && p_insync && !p_sent && !p_quiet) begin
			r.send_data = 1'b1;
			r.trailer_hops = (p_own == 8'd0) ? 8'd0 : p_hops;
			p_sent = 1'b1;
			p_rep_cnt = 8'd0;
			p_reporting = 1'b1;
		end else if (p_slot == p_total) begin
			if (p_own == 8'd0 && !p_quiet && !p_sent) begin
				p_sent = 1'b1;
				r.send_sync = 1'b1;
			end
			if (!it.config_mode && p_reporting) begin
				r.report_rssi = 1'b1;
				r.report_index = p_rep_cnt;
				r.report_value = (int'(p_rep_cnt) < N_RSSI) ? p_rssi[p_rep_cnt] : 8'd0;
				p_reporting = it.report_more;
				if (p_rep_cnt != SAT_MAX)
					p_rep_cnt = p_rep_cnt + 8'd1;
				if (int'(p_rep_cnt) >= N_RSSI || p_rep_cnt >= p_total)
					p_reporting = 1'b0;
			end
		end
		r.synced = p_insync;
		r.slot_now = p_slot;
		r.silent = p_quiet;
		r.link_led = p_led;
		return r;
	endfunction

	function automatic in_item_t ev(bit f, int t, int len, int snd, int rssi, bit cm, bit more);
		in_item_t it;
		it.func = f;
		it.time_now = 16'(t);
		it.pkt_len = 8'(len);
		it.sender_id = 8'(snd);
		it.packet_rssi = 8'(rssi);
		it.config_mode = cm;
		it.report_more = more;
		return it;
	endfunction

	function automatic out_item_t seen(bit sd, bit ss, bit rep, int slot, bit sil);
		out_item_t r;
		r = '0;
		r.send_data = sd;
		r.send_sync = ss;
		r.report_rssi = rep;
		r.synced = 1'b1;
		r.slot_now = 8'(slot);
		r.silent = sil;
		return r;
	endfunction

	function automatic in_item_t next_event();
		in_item_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			tick = 16'($urandom);
		else if (pick < 30)
			tick += 16'($urandom_range(1600, 400));
		else if (pick >= 40)
			tick += 16'($urandom_range(400));
		it.time_now = tick;
		it.func = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 10)
			it.sender_id = {1'b1, 7'($urandom)};
		else if (pick < 85)
			it.sender_id = 8'($urandom_range(19));
		else
			it.sender_id = 8'($urandom);
		it.pkt_len = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(70));
		it.packet_rssi = 8'($urandom);
		it.config_mode = ($urandom_range(9) == 0);
		it.report_more = ($urandom_range(9) < 7);
		return it;
	endfunction

	function automatic string bad_fields(out_item_t e, out_item_t a);
		string s = "";
		if (a.send_data !== e.send_data) s = {s, " send_data"};
		if (a.send_sync !== e.send_sync) s = {s, " send_sync"};
		if (a.trailer_hops !== e.trailer_hops) s = {s, " trailer_hops"};
		if (a.forward_user !== e.forward_user) s = {s, " forward_user"};
		if (a.forward_len !== e.forward_len) s = {s, " forward_len"};
		if (a.report_rssi !== e.report_rssi) s = {s, " report_rssi"};
		if (a.report_index !== e.report_index) s = {s, " report_index"};
		if (a.report_value !== e.report_value) s = {s, " report_value"};
		if (a.synced !== e.synced) s = {s, " synced"};
		if (a.slot_now !== e.slot_now) s = {s, " slot_now"};
		if (a.silent !== e.silent) s = {s, " silent"};
		if (a.link_led !== e.link_led) s = {s, " link_led"};
		return s;
	endfunction

	function automatic void note_fail(string msg);
		errs++;
		if (errs <= 10)
			$display("%s", msg);
	endfunction

	task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
		out_item_t got;
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = sched_step(it);
		pending_res.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [7:0] own, input logic [7:0] total);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OWN_NODE;
		cfg_data <= own;
		@(negedge clk);
		cfg_index <= CFG_NODE_TOTAL;
		cfg_data <= total;
		@(negedge clk);
		cfg_we <= 1'b0;
		p_own = own;
		p_insync = (own == 8'd0);
		p_total = total;
		p_slot = total;
	endtask

	// receiver stall, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 150;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_idle);
		end
	end

	always @(posedge clk) begin : chk
		out_item_t want_r;
		string diff;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_res.size() == 0) begin
				note_fail($sformatf("unexpected transfer: got %p", out_data));
			end else begin
				want_r = pending_res.pop_front();
				diff = bad_fields(want_r, out_data);
				if (diff != "")
					note_fail($sformatf("mismatch:%s\n  exp %p\n  got %p", diff, want_r,
						out_data));
			end
		end
	end

	initial begin
		logic [7:0] own_set [6];
		logic [7:0] tot_set [6];
		own_set = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd17, 8'd0};
		tot_set = '{8'd5, 8'd254, 8'd254, 8'd1, 8'd20, 8'd3};
		reset_sched();

		plan.push_back('{ev(0, 0, 0, 0, 0, 0, 1), 1'b1, seen(0, 0, 1, 1, 1)});
		plan.push_back('{ev(0, 700, 0, 0, 0, 0, 1), 1'b1, seen(0, 1, 0, 1, 0)});
		plan.push_back('{ev(0, 800, 0, 0, 0, 0, 1), 1'b1, seen(0, 0, 0, 0, 1)});
		plan.push_back('{ev(0, 1000, 0, 0, 0, 0, 1), 1'b1, seen(1, 0, 0, 0, 0)});
		plan.push_back('{ev(0, 1000, 0, 0, 0, 1, 1), 1'b0, '0});
		plan.push_back('{ev(1, 1100, 0, 'h80, 'h11, 0, 1), 1'b1, seen(0, 0, 0, 1, 0)});
		plan.push_back('{ev(1, 1100, 255, 'hFF, 'h22, 0, 0), 1'b0, '0});
		plan.push_back('{ev(0, 1104, 0, 0, 0, 0, 1), 1'b0, '0});
		plan.push_back('{ev(1, 1110, 2, 5, 'hFF, 0, 1), 1'b0, '0});
		plan.push_back('{ev(1, 1120, 1, 15, 'hAA, 0, 1), 1'b0, '0});
		plan.push_back('{ev(1, 1130, 100, 16, 'h55, 1, 1), 1'b0, '0});
		plan.push_back('{ev(1, 1140, 10, 'h7F, 'h01, 0, 1), 1'b0, '0});
		plan.push_back('{ev(1, 1150, 60, 'h8F, 'h00, 0, 1), 1'b0, '0});
		plan.push_back('{ev(1, 1150, 61, 'hC0, 'h33, 0, 1), 1'b0, '0});
		plan.push_back('{ev(0, 1160, 0, 0, 0, 0, 1), 1'b0, '0});
		plan.push_back('{ev(0, 40000, 0, 0, 0, 0, 1), 1'b0, '0});
		plan.push_back('{ev(0, 65535, 255, 255, 255, 0, 0), 1'b0, '0});
		plan.push_back('{ev(0, 5, 0, 0, 0, 1, 1), 1'b0, '0});
		plan.push_back('{ev(0, 800, 0, 0, 0, 0, 1), 1'b0, '0});
		plan.push_back('{ev(0, 1600, 0, 0, 0, 0, 1), 1'b0, '0});
		plan.push_back('{ev(0, 2400, 0, 0, 0, 0, 1), 1'b0, '0});
		plan.push_back('{ev(0, 3200, 0, 0, 0, 0, 1), 1'b0, '0});
		plan.push_back('{ev(0, 4000, 0, 0, 0, 0, 1), 1'b0, '0});
		plan.push_back('{ev(1, 4100, 255, 0, 'hFF, 1, 1), 1'b0, '0});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_item(plan[i].it, plan[i].typed, plan[i].want);

		for (int ph = 0; ph < 6; ph++) begin
			in_valid <= 1'b0;
			while (pending_res.size() != 0)
				@(negedge clk);
			apply_config(own_set[ph], tot_set[ph]);
			src_idle = (ph < 2) ? 10 : (ph < 4) ? 83 : 0;
			sink_idle = (ph < 2) ? 83 : (ph < 4) ? 10 : 0;
			if (ph == 0 || ph == 4)
				hold_req = 1'b1;
			repeat (180)
				send_item(next_event(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		for (int i = 0; i < 20000 && pending_res.size() != 0; i++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errs == 0 && pending_res.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
